>>> src/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, register map and gesture codes for the button gesture
// classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int unsigned CntW     = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = 4;

  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_CLICK  = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_SHORT_MIN  = 2'd2,
    REG_DOUBLE_GAP = 2'd3
  } reg_idx_t;

  localparam cnt_t DebounceRst  = 16'd5;
  localparam cnt_t LongPressRst = 16'd200;
  localparam cnt_t ShortMinRst  = 16'd5;
  localparam cnt_t DoubleGapRst = 16'd30;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : cnt_t'(v + 1'b1);
  endfunction

endpackage

>>> src/bgc_stream_if.sv
// ----------------------------------------------------------------------------
// bgc_stream_if
// Valid/ready channels of the classifier: tick beats in, gesture beats out.
// ----------------------------------------------------------------------------
interface bgc_in_if;
  logic valid;
  logic ready;
  logic key_pressed;

  modport source (output valid, output key_pressed, input ready);
  modport sink   (input valid, input key_pressed, output ready);
endinterface

interface bgc_out_if;
  import bgc_pkg::*;
  logic     valid;
  logic     ready;
  gesture_t gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface

>>> src/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Debounces a sampled button level and reports click, double click or
// long press, one gesture beat per tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per scan tick, carrying key_pressed.
//   out_ch : one beat per tick, gesture 0 none, 1 click, 2 double, 3 long.
//   APB    : four 16-bit registers at 0x0 debounce, 0x4 long press,
//            0x8 short minimum, 0xC double gap; write only while idle.
// Output: a tick's gesture is registered in the output or the skid buffer.
// Throughput: one tick per cycle while the skid buffer is empty; the
//   step/counter update is one compare-and-increment between state registers.
// Stalls: an output register plus a one-entry skid buffer; in_ch.ready
//   drops only when both hold a gesture not yet taken.
// Reset: state goes idle, counter zero, registers to 5/200/5/30, output
//   and skid buffer empty.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
  input  logic                      clk,
  input  logic                      rst_n,
  bgc_in_if.sink                    in_ch,
  bgc_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bgc_pkg::AddrW-1:0] paddr,
  input  logic [bgc_pkg::DataW-1:0] pwdata,
  output logic [bgc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import bgc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_HOLD     = 3'd2,
    ST_CLASSIFY = 3'd3,
    ST_GAP      = 3'd4,
    ST_SECOND   = 3'd5
  } step_t;

  cnt_t     debounce_r, long_press_r, short_min_r, double_gap_r;
  step_t    step_r, step_nxt;
  cnt_t     count_r, count_nxt, count_inc;
  gesture_t gest_nxt;
  gesture_t out_gest_r, skid_gest_r;
  logic     out_valid_r, skid_valid_r;
  logic     accept, pop, cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_DEBOUNCE:   prdata = DataW'(debounce_r);
      REG_LONG_PRESS: prdata = DataW'(long_press_r);
      REG_SHORT_MIN:  prdata = DataW'(short_min_r);
      REG_DOUBLE_GAP: prdata = DataW'(double_gap_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DebounceRst;
      long_press_r <= LongPressRst;
      short_min_r  <= ShortMinRst;
      double_gap_r <= DoubleGapRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DEBOUNCE:   debounce_r   <= pwdata[CntW-1:0];
        REG_LONG_PRESS: long_press_r <= pwdata[CntW-1:0];
        REG_SHORT_MIN:  short_min_r  <= pwdata[CntW-1:0];
        REG_DOUBLE_GAP: double_gap_r <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = ~skid_valid_r;
  assign accept      = in_ch.valid & in_ch.ready;
  assign pop         = out_valid_r & out_ch.ready;
  assign count_inc   = sat_inc(count_r);

  always_comb begin
    step_nxt  = step_r;
    count_nxt = count_r;
    gest_nxt  = GEST_NONE;
    unique case (step_r)
      ST_IDLE: begin
        if (in_ch.key_pressed) step_nxt = ST_DEBOUNCE;
      end
      ST_DEBOUNCE: begin
        count_nxt = count_inc;
        if (count_inc >= debounce_r) begin
          step_nxt  = in_ch.key_pressed ? ST_HOLD : ST_IDLE;
          count_nxt = '0;
        end
      end
      ST_HOLD: begin
        if (in_ch.key_pressed) count_nxt = count_inc;
        else                   step_nxt  = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        count_nxt = '0;
        if (count_r > long_press_r) begin
          gest_nxt = GEST_LONG;
          step_nxt = ST_IDLE;
        end else if (count_r > short_min_r) begin
          step_nxt = ST_GAP;
        end else begin
          step_nxt = ST_IDLE;
        end
      end
      ST_GAP: begin
        count_nxt = count_inc;
        if (count_inc > double_gap_r) begin
          count_nxt = '0;
          if (in_ch.key_pressed) begin
            step_nxt = ST_SECOND;
          end else begin
            gest_nxt = GEST_CLICK;
            step_nxt = ST_IDLE;
          end
        end
      end
      ST_SECOND: begin
        if (in_ch.key_pressed) begin
          count_nxt = count_inc;
        end else begin
          gest_nxt  = GEST_DOUBLE;
          step_nxt  = ST_IDLE;
          count_nxt = '0;
        end
      end
      default: begin
        step_nxt  = ST_IDLE;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        step_r  <= step_nxt;
        count_r <= count_nxt;
      end
      if (skid_valid_r) begin
        if (pop) begin
          out_gest_r   <= skid_gest_r;
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r || pop) begin
          out_gest_r  <= gest_nxt;
          out_valid_r <= 1'b1;
        end else begin
          skid_gest_r  <= gest_nxt;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.gesture = out_gest_r;

endmodule

>>> src/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_checker
// Port-level checks on the classifier's beat flow, bound to the top level.
// ----------------------------------------------------------------------------
module bgc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_gesture
);

  // output is empty right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gesture))
    else $error("stalled gesture beat changed");

  // input backpressure only with a gesture pending
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !$past(out_ready))
    else $error("input stalled without pending output");

  // a tick on an empty output shows its gesture next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("tick beat produced no gesture beat");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_gesture (out_ch.gesture)
);

>>> tb/tb_button_gesture_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_gesture_classifier
// Drives scan-tick beats into the classifier and checks every gesture beat
// against a local model of the six-step scan machine. A short directed table
// covers click, double click, long press and a rejected bounce. Randomized
// press patterns then run under several register settings, the extremes
// among them, with random stalls on both channels and a long output
// hold-off. The run ends with mid-wait register changes and a gap window
// held open until its register is lowered.
// ----------------------------------------------------------------------------
module tb_button_gesture_classifier;
  import bgc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DEBOUNCE, ST_HOLD, ST_CLASSIFY, ST_GAP, ST_SECOND
  } scan_step_t;

  typedef struct packed {
    logic     key;
    logic     pinned;
    gesture_t gest;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  bgc_in_if  in_ch();
  bgc_out_if out_ch();

  button_gesture_classifier dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scan machine copy and its registers
  scan_step_t pred_step  = ST_IDLE;
  cnt_t       pred_count = '0;
  cnt_t       db_ticks    = DebounceRst;
  cnt_t       long_ticks  = LongPressRst;
  cnt_t       short_ticks = ShortMinRst;
  cnt_t       gap_ticks   = DoubleGapRst;

  gesture_t gesture_expected[$];
  logic     pin_valid = 1'b0;
  gesture_t pin_gest  = GEST_NONE;
  logic     idle_en   = 1'b1;
  logic     stall_req = 1'b0;
  int       err_count  = 0;
  int       ticks_sent = 0;
  int       reg_writes = 0;
  int       in_stalls  = 0;
  int       gest_hits [4] = '{0, 0, 0, 0};

  // directed rows: reset idle, bounce, long press, click, double click
  dir_row_t dir_rows [27] = '{
    '{1'b0, 1'b1, GEST_NONE},
    '{1'b1, 1'b0, GEST_NONE}, '{1'b0, 1'b1, GEST_NONE},
    '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE},
    '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE},
    '{1'b0, 1'b0, GEST_NONE}, '{1'b0, 1'b1, GEST_LONG},
    '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE},
    '{1'b0, 1'b0, GEST_NONE}, '{1'b0, 1'b0, GEST_NONE}, '{1'b0, 1'b0, GEST_NONE},
    '{1'b0, 1'b1, GEST_CLICK},
    '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE},
    '{1'b0, 1'b0, GEST_NONE}, '{1'b0, 1'b0, GEST_NONE}, '{1'b0, 1'b0, GEST_NONE},
    '{1'b1, 1'b0, GEST_NONE}, '{1'b1, 1'b0, GEST_NONE}, '{1'b0, 1'b1, GEST_DOUBLE}
  };

  function automatic cnt_t bump(input cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic int clip(input int v, input int hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic gesture_t classify_tick(input logic key);
    gesture_t g;
    g = GEST_NONE;
    case (pred_step)
      ST_IDLE: begin
        if (key) pred_step = ST_DEBOUNCE;
      end
      ST_DEBOUNCE: begin
        pred_count = bump(pred_count);
        if (pred_count >= db_ticks) begin
          pred_step  = key ? ST_HOLD : ST_IDLE;
          pred_count = '0;
        end
      end
      ST_HOLD: begin
        if (key) pred_count = bump(pred_count);
        else pred_step = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (pred_count > long_ticks) begin
          g = GEST_LONG;
          pred_step = ST_IDLE;
        end else if (pred_count > short_ticks) begin
          pred_step = ST_GAP;
        end else begin
          pred_step = ST_IDLE;
        end
        pred_count = '0;
      end
      ST_GAP: begin
        pred_count = bump(pred_count);
        if (pred_count > gap_ticks) begin
          if (key) begin
            pred_step = ST_SECOND;
          end else begin
            g = GEST_CLICK;
            pred_step = ST_IDLE;
          end
          pred_count = '0;
        end
      end
      ST_SECOND: begin
        if (key) begin
          pred_count = bump(pred_count);
        end else begin
          g = GEST_DOUBLE;
          pred_step  = ST_IDLE;
          pred_count = '0;
        end
      end
      default: begin
        pred_step  = ST_IDLE;
        pred_count = '0;
      end
    endcase
    return g;
  endfunction

  // beat monitor: compare gestures, then predict for the accepted tick
  always @(posedge clk) begin
    gesture_t want, got;
    if (rst_n) begin
      if (in_ch.valid && !in_ch.ready) in_stalls++;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.gesture;
        if (gesture_expected.size() == 0) begin
          $display("%0t: unexpected gesture beat, expected none, actual %0d", $time, got);
          err_count++;
        end else begin
          want = gesture_expected.pop_front();
          if (got !== want) begin
            $display("%0t: gesture mismatch, expected %0d, actual %0d", $time, want, got);
            err_count++;
          end else begin
            gest_hits[got]++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = classify_tick(in_ch.key_pressed);
        gesture_expected.push_back(pin_valid ? pin_gest : want);
      end
    end
  end

  // gesture receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_req) begin
        stall_req = 1'b0;
        hold_left = 60;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_en && $urandom_range(0, 99) < 26);
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_tick(input logic key, input logic pinned, input gesture_t gest);
    while (idle_en && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.key_pressed <= key;
    pin_valid = pinned;
    pin_gest  = gest;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (gesture_expected.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input cnt_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEBOUNCE:   db_ticks    = val;
      REG_LONG_PRESS: long_ticks  = val;
      REG_SHORT_MIN:  short_ticks = val;
      REG_DOUBLE_GAP: gap_ticks   = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, val}) begin
      $display("%0t: readback mismatch at reg %0d, expected %0h, actual %0h",
               $time, idx, val, prdata);
      err_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input cnt_t db, input cnt_t lp, input cnt_t sm, input cnt_t gap);
    drain();
    write_reg(REG_DEBOUNCE, db);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_SHORT_MIN, sm);
    write_reg(REG_DOUBLE_GAP, gap);
  endtask

  // one gesture-shaped sequence sized to the current registers
  task automatic press_pattern();
    int kind, hold, rel;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'b0, GEST_NONE);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8))
        send_tick($urandom_range(0, 1) == 1, 1'b0, GEST_NONE);
    end else if (kind == 1) begin
      repeat ($urandom_range(1, clip(db_ticks, 40) + 1)) send_tick(1'b1, 1'b0, GEST_NONE);
      repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0, GEST_NONE);
    end else begin
      case ($urandom_range(0, 5))
        0: hold = short_ticks;
        1: hold = short_ticks + 1;
        2: hold = long_ticks;
        3: hold = long_ticks + 1;
        4: hold = long_ticks + 2;
        default: hold = $urandom_range(0, clip(long_ticks, 300) + 3);
      endcase
      repeat (1 + clip(db_ticks, 40) + clip(hold, 300)) send_tick(1'b1, 1'b0, GEST_NONE);
      rel = 2 + $urandom_range(0, clip(gap_ticks, 60) + 2);
      repeat (rel) send_tick(1'b0, 1'b0, GEST_NONE);
      if (kind >= 6) begin
        repeat ($urandom_range(1, 6)) send_tick(1'b1, 1'b0, GEST_NONE);
        repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0, GEST_NONE);
      end
    end
  endtask

  task automatic run_random(input int n, input logic hold_off);
    int stop_at;
    stop_at = ticks_sent + n;
    stall_req = hold_off;
    while (ticks_sent < stop_at) press_pattern();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.key_pressed = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_config(16'd1, 16'd3, 16'd0, 16'd1);
    foreach (dir_rows[i])
      send_tick(dir_rows[i].key, dir_rows[i].pinned, dir_rows[i].gest);

    set_config(DebounceRst, LongPressRst, ShortMinRst, DoubleGapRst);
    run_random(200, 1'b1);
    idle_en = 1'b0;
    set_config(16'd2, 16'd12, 16'd3, 16'd4);
    run_random(160, 1'b0);
    idle_en = 1'b1;
    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(100, 1'b1);
    // short minimum above long threshold
    set_config(16'd1, 16'd4, 16'd9, 16'd0);
    run_random(100, 1'b1);
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    run_random(60, 1'b1);
    set_config(16'hFFFF, 16'd0, 16'd0, 16'd2);
    run_random(50, 1'b0);
    set_config(16'd3, 16'd20, 16'd6, 16'd8);
    run_random(120, 1'b1);
    repeat (2) begin
      set_config(cnt_t'($urandom_range(0, 6)), cnt_t'($urandom_range(0, 30)),
                 cnt_t'($urandom_range(0, 10)), cnt_t'($urandom_range(0, 12)));
      run_random(80, 1'b1);
    end

    // debounce lowered while a press is waiting for confirmation
    set_config(16'hFFFF, 16'd10, 16'd1, 16'd2);
    repeat (20) send_tick(1'b1, 1'b0, GEST_NONE);
    drain();
    write_reg(REG_DEBOUNCE, 16'd3);
    repeat (6) send_tick(1'b1, 1'b0, GEST_NONE);
    repeat (8) send_tick(1'b0, 1'b0, GEST_NONE);

    // gap window that never closes until the register is lowered
    set_config(16'd1, 16'd10, 16'd0, 16'hFFFF);
    repeat (4) send_tick(1'b1, 1'b0, GEST_NONE);
    repeat (40) send_tick(1'b0, 1'b0, GEST_NONE);
    drain();
    write_reg(REG_DOUBLE_GAP, 16'd5);
    repeat (4) send_tick(1'b0, 1'b0, GEST_NONE);

    drain();
    repeat (4) @(posedge clk);
    if (gesture_expected.size() != 0) begin
      $display("%0t: %0d gesture beats never arrived", $time, gesture_expected.size());
      err_count++;
    end
    $display("Sent %0d tick beats across %0d register writes; input held off %0d cycles.",
             ticks_sent, reg_writes, in_stalls);
    $display("Gestures matched: %0d click, %0d double click, %0d long press.",
             gest_hits[GEST_CLICK], gest_hits[GEST_DOUBLE], gest_hits[GEST_LONG]);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out with %0d beats outstanding", $time, gesture_expected.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
src/bgc_pkg.sv
src/bgc_stream_if.sv
src/button_gesture_classifier.sv
src/bgc_checker.sv
tb/tb_button_gesture_classifier.sv
